// ===== sv/obb_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants and types of the oriented box overlap test unit.
// ----------------------------------------------------------------------------
package obb_pkg;

  // Default widths: directions Q1.15, positions and lengths Q16.16
  localparam int DIR_WIDTH_DEF = 16;
  localparam int POS_WIDTH_DEF = 32;

  // Box register file: three axis rows per box, two boxes
  localparam int NUM_ROWS = 6;
  localparam int ROW_AW   = 3;
  localparam logic [ROW_AW-1:0] ROW_BOX_B = 3'd3;

  // Box select and axis codes of an input beat
  localparam logic       BOX_A     = 1'b0;
  localparam logic       BOX_B     = 1'b1;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Command to the shared multiply-accumulate unit
  typedef struct packed {
    logic en;   // update the accumulator
    logic clr;  // start a new sum
    logic neg;  // subtract the product
    logic shl;  // weight the product by the upper half shift
  } mac_cmd_t;

endpackage

// ===== sv/obb_store.sv =====
// ----------------------------------------------------------------------------
// obb_store
// Box register file: axis directions, half lengths and the two box centers.
// ----------------------------------------------------------------------------
module obb_store #(
  parameter int DIR_WIDTH = obb_pkg::DIR_WIDTH_DEF,
  parameter int POS_WIDTH = obb_pkg::POS_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic                               wr_box,
  input  logic [1:0]                         wr_axis,
  input  logic signed [DIR_WIDTH-1:0]        wr_dir [3],
  input  logic [POS_WIDTH-2:0]               wr_len,
  input  logic signed [POS_WIDTH-1:0]        wr_cen [3],
  input  logic [obb_pkg::ROW_AW-1:0]         rd_addr,
  output logic signed [DIR_WIDTH-1:0]        rd_row [3],
  output logic [POS_WIDTH-2:0]               rd_len,
  output logic signed [POS_WIDTH-1:0]        cen_a [3],
  output logic signed [POS_WIDTH-1:0]        cen_b [3]
);
  import obb_pkg::*;

  logic signed [DIR_WIDTH-1:0] dir_r [NUM_ROWS][3];
  logic [POS_WIDTH-2:0]        len_r [NUM_ROWS];
  logic signed [POS_WIDTH-1:0] cen_r [2][3];
  logic [ROW_AW-1:0]           wr_addr;

  // Row of the written axis
  assign wr_addr = (wr_box == BOX_B) ? (ROW_BOX_B + ROW_AW'(wr_axis)) : ROW_AW'(wr_axis);

  // Store one axis and overwrite that box's center
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int c = 0; c < 3; c++) begin
        dir_r[wr_addr][c] <= wr_dir[c];
        cen_r[wr_box][c]  <= wr_cen[c];
      end
      len_r[wr_addr] <= wr_len;
    end
  end

  // Read one row per cycle; centers sit at fixed places
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rd_row[c] = dir_r[rd_addr][c];
      cen_a[c]  = cen_r[0][c];
      cen_b[c]  = cen_r[1][c];
    end
    rd_len = len_r[rd_addr];
  end

endmodule

// ===== sv/obb_mac.sv =====
// ----------------------------------------------------------------------------
// obb_mac
// Shared signed multiply-accumulate unit with optional negate and shift.
// ----------------------------------------------------------------------------
module obb_mac #(
  parameter int MW    = 33,
  parameter int ACC_W = 94,
  parameter int SHIFT = 25
) (
  input  logic                    clk,
  input  obb_pkg::mac_cmd_t       cmd,
  input  logic signed [MW-1:0]    op_a,
  input  logic signed [MW-1:0]    op_b,
  output logic signed [ACC_W-1:0] acc
);
  import obb_pkg::*;

  logic signed [2*MW-1:0]  prod;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  // Form the weighted, signed product term
  always_comb begin
    prod = op_a * op_b;
    term = ACC_W'(prod);
    if (cmd.shl) begin
      term = term <<< SHIFT;
    end
    if (cmd.neg) begin
      term = -term;
    end
    base    = cmd.clr ? '0 : acc_r;
    acc_nxt = cmd.en ? (base + term) : acc_r;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== sv/obb_overlap_test_unit.sv =====
// ----------------------------------------------------------------------------
// obb_overlap_test_unit
// Oriented box overlap test by fifteen separating axes on one shared
// multiply-accumulate unit under a sequencer.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+---------------------------
//  input    | in_mode, in_axis_index, in_dir_*,      | beat taken when start && !busy
//           | in_half_len, in_center_*               |
//  result   | out_collides                           | out_valid strobe, one cycle
//
// The beat that loads axis 2 of box B runs the test: it forms the center
// distance, then takes the face axes and the cross axes in turn on the single
// multiplier that every product passes through. The test stops at the first
// separating axis. Reset clears the sequencer and the result strobe; stored
// boxes hold no reset. The result cannot be stalled.
// ----------------------------------------------------------------------------
module obb_overlap_test_unit #(
  parameter int DIR_WIDTH = obb_pkg::DIR_WIDTH_DEF,
  parameter int POS_WIDTH = obb_pkg::POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [1:0]                  in_axis_index,
  input  logic signed [DIR_WIDTH-1:0] in_dir_x,
  input  logic signed [DIR_WIDTH-1:0] in_dir_y,
  input  logic signed [DIR_WIDTH-1:0] in_dir_z,
  input  logic [POS_WIDTH-2:0]        in_half_len,
  input  logic signed [POS_WIDTH-1:0] in_center_x,
  input  logic signed [POS_WIDTH-1:0] in_center_y,
  input  logic signed [POS_WIDTH-1:0] in_center_z,
  output logic                        out_valid,
  output logic                        out_collides
);
  import obb_pkg::*;

  // Datapath widths
  localparam int F     = DIR_WIDTH - 1;
  localparam int SW    = 2 * DIR_WIDTH + 1;          // test axis component
  localparam int DSW   = POS_WIDTH + 1;              // center distance
  localparam int DOTW  = SW + DIR_WIDTH + 1;         // axis dot direction
  localparam int H     = (DOTW + 1) / 2;             // split of the magnitude
  localparam int MW0   = (SW > DSW) ? SW : DSW;
  localparam int MW    = (MW0 > H + 1) ? MW0 : H + 1;
  localparam int LW    = SW + DSW + 2;               // |axis . distance|
  localparam int ACC_W = 2 * MW + H + 3;
  localparam int CMPW  = ACC_W + DIR_WIDTH;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_AXIS  = 4'd2;
  localparam logic [3:0] ST_CROSS = 4'd3;
  localparam logic [3:0] ST_DIST  = 4'd4;
  localparam logic [3:0] ST_LSAVE = 4'd5;
  localparam logic [3:0] ST_DOT   = 4'd6;
  localparam logic [3:0] ST_MAG   = 4'd7;
  localparam logic [3:0] ST_RLO   = 4'd8;
  localparam logic [3:0] ST_RHI   = 4'd9;
  localparam logic [3:0] ST_RADD  = 4'd10;
  localparam logic [3:0] ST_CMP   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       res_r, res_nxt;

  // Axis walk: face axes of A then B, then cross axes A_i x B_j
  logic       cross_r, cross_nxt;
  logic       fb_r, fb_nxt;
  logic [1:0] fi_r, fi_nxt;
  logic [1:0] fj_r, fj_nxt;
  // Radius term walk and small counters
  logic       tb_r, tb_nxt;
  logic [1:0] tk_r, tk_nxt;
  logic [1:0] c_r, c_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  logic signed [SW-1:0]        s_r [3];
  logic signed [SW-1:0]        s_nxt [3];
  logic signed [DIR_WIDTH-1:0] a_r [3];
  logic signed [DIR_WIDTH-1:0] a_nxt [3];
  logic signed [DSW-1:0]       dist_r [3];
  logic signed [DSW-1:0]       dist_nxt [3];
  logic [LW-1:0]               l_r, l_nxt;
  logic [DOTW-1:0]             mag_r, mag_nxt;
  logic [ACC_W-1:0]            r_r, r_nxt;

  // Store and MAC connections
  logic                        accept;
  logic                        trig;
  logic [ROW_AW-1:0]           rd_addr;
  logic signed [DIR_WIDTH-1:0] wr_dir [3];
  logic signed [POS_WIDTH-1:0] wr_cen [3];
  logic signed [DIR_WIDTH-1:0] rd_row [3];
  logic [POS_WIDTH-2:0]        rd_len;
  logic signed [POS_WIDTH-1:0] cen_a [3];
  logic signed [POS_WIDTH-1:0] cen_b [3];
  mac_cmd_t                    cmd;
  logic signed [MW-1:0]        op_a, op_b;
  logic signed [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]            acc_abs;
  logic [1:0]                  ax_sel, qy_sel;
  logic                        incl;
  logic                        sep;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign trig   = (in_mode == BOX_B) && (in_axis_index == AXIS_LAST);

  assign wr_dir[0] = in_dir_x;
  assign wr_dir[1] = in_dir_y;
  assign wr_dir[2] = in_dir_z;
  assign wr_cen[0] = in_center_x;
  assign wr_cen[1] = in_center_y;
  assign wr_cen[2] = in_center_z;

  obb_store #(
    .DIR_WIDTH (DIR_WIDTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && (in_axis_index <= AXIS_LAST)),
    .wr_box  (in_mode),
    .wr_axis (in_axis_index),
    .wr_dir  (wr_dir),
    .wr_len  (in_half_len),
    .wr_cen  (wr_cen),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .rd_len  (rd_len),
    .cen_a   (cen_a),
    .cen_b   (cen_b)
  );

  obb_mac #(
    .MW    (MW),
    .ACC_W (ACC_W),
    .SHIFT (H)
  ) u_mac (
    .clk  (clk),
    .cmd  (cmd),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  // Is the current radius term part of this axis?
  always_comb begin
    if (cross_r) begin
      incl = (!tb_r && (tk_r != fi_r)) || (tb_r && (tk_r != fj_r));
    end else begin
      incl = (tb_r != fb_r);
    end
  end

  // Cross product operand picks
  always_comb begin
    unique case (cnt_r)
      3'd0:    begin ax_sel = 2'd1; qy_sel = 2'd2; end
      3'd1:    begin ax_sel = 2'd2; qy_sel = 2'd1; end
      3'd2:    begin ax_sel = 2'd2; qy_sel = 2'd0; end
      3'd3:    begin ax_sel = 2'd0; qy_sel = 2'd2; end
      3'd4:    begin ax_sel = 2'd0; qy_sel = 2'd1; end
      3'd5:    begin ax_sel = 2'd1; qy_sel = 2'd0; end
      default: begin ax_sel = 2'd0; qy_sel = 2'd0; end
    endcase
  end

  assign sep = (CMPW'(l_r) << F) > CMPW'(r_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    cross_nxt     = cross_r;
    fb_nxt        = fb_r;
    fi_nxt        = fi_r;
    fj_nxt        = fj_r;
    tb_nxt        = tb_r;
    tk_nxt        = tk_r;
    c_nxt         = c_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    a_nxt         = a_r;
    dist_nxt      = dist_r;
    l_nxt         = l_r;
    mag_nxt       = mag_r;
    r_nxt         = r_r;
    cmd           = '0;
    op_a          = '0;
    op_b          = '0;
    rd_addr       = tb_r ? (ROW_BOX_B + ROW_AW'(tk_r)) : ROW_AW'(tk_r);

    unique case (state_r)
      ST_IDLE: begin
        if (accept && trig) begin
          state_nxt = ST_DIFF;
        end
      end
      // Form the center distance, start on face axis 0 of box A
      ST_DIFF: begin
        for (int c = 0; c < 3; c++) begin
          dist_nxt[c] = DSW'(cen_a[c]) - DSW'(cen_b[c]);
        end
        cross_nxt = 1'b0;
        fb_nxt    = BOX_A;
        fi_nxt    = '0;
        fj_nxt    = '0;
        state_nxt = ST_AXIS;
      end
      // Load the test axis (face) or the A row of the cross product
      ST_AXIS: begin
        if (cross_r) begin
          rd_addr   = ROW_AW'(fi_r);
          a_nxt     = rd_row;
          r_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CROSS;
        end else begin
          rd_addr = fb_r ? (ROW_BOX_B + ROW_AW'(fi_r)) : ROW_AW'(fi_r);
          for (int c = 0; c < 3; c++) begin
            s_nxt[c] = SW'(rd_row[c]);
          end
          r_nxt     = ACC_W'(rd_len) << (2 * F);
          c_nxt     = '0;
          state_nxt = ST_DIST;
        end
      end
      // Cross product, two products per component
      ST_CROSS: begin
        rd_addr  = ROW_BOX_B + ROW_AW'(fj_r);
        op_a     = MW'(a_r[ax_sel]);
        op_b     = MW'(rd_row[qy_sel]);
        cmd.en   = 1'b1;
        cmd.clr  = !cnt_r[0];
        cmd.neg  = cnt_r[0];
        if (cnt_r == 3'd2) begin
          s_nxt[0] = SW'(acc);
        end
        if (cnt_r == 3'd4) begin
          s_nxt[1] = SW'(acc);
        end
        if (cnt_r == 3'd5) begin
          c_nxt     = '0;
          state_nxt = ST_DIST;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      // Project the center distance on the axis
      ST_DIST: begin
        if (cross_r && (c_r == 2'd0)) begin
          s_nxt[2] = SW'(acc);
        end
        op_a    = MW'(s_r[c_r]);
        op_b    = MW'(dist_r[c_r]);
        cmd.en  = 1'b1;
        cmd.clr = (c_r == 2'd0);
        if (c_r == 2'd2) begin
          state_nxt = ST_LSAVE;
        end else begin
          c_nxt = c_r + 2'd1;
        end
      end
      ST_LSAVE: begin
        l_nxt     = LW'(acc_abs);
        tb_nxt    = 1'b0;
        tk_nxt    = '0;
        c_nxt     = '0;
        state_nxt = ST_DOT;
      end
      // Axis dot one box direction; skip terms that do not apply
      ST_DOT: begin
        if (!incl) begin
          c_nxt = '0;
          if (tb_r && (tk_r == 2'd2)) begin
            state_nxt = ST_CMP;
          end else if (tk_r == 2'd2) begin
            tb_nxt = 1'b1;
            tk_nxt = '0;
          end else begin
            tk_nxt = tk_r + 2'd1;
          end
        end else begin
          op_a    = MW'(s_r[c_r]);
          op_b    = MW'(rd_row[c_r]);
          cmd.en  = 1'b1;
          cmd.clr = (c_r == 2'd0);
          if (c_r == 2'd2) begin
            state_nxt = ST_MAG;
          end else begin
            c_nxt = c_r + 2'd1;
          end
        end
      end
      ST_MAG: begin
        mag_nxt   = DOTW'(acc_abs);
        state_nxt = ST_RLO;
      end
      // Magnitude times half length, lower then upper half
      ST_RLO: begin
        op_a      = MW'(mag_r[H-1:0]);
        op_b      = MW'(rd_len);
        cmd.en    = 1'b1;
        cmd.clr   = 1'b1;
        state_nxt = ST_RHI;
      end
      ST_RHI: begin
        op_a      = MW'(mag_r[DOTW-1:H]);
        op_b      = MW'(rd_len);
        cmd.en    = 1'b1;
        cmd.shl   = 1'b1;
        state_nxt = ST_RADD;
      end
      // Add the term into the radius sum, advance to the next term
      ST_RADD: begin
        r_nxt = r_r + ACC_W'(acc);
        c_nxt = '0;
        if (tb_r && (tk_r == 2'd2)) begin
          state_nxt = ST_CMP;
        end else if (tk_r == 2'd2) begin
          tb_nxt    = 1'b1;
          tk_nxt    = '0;
          state_nxt = ST_DOT;
        end else begin
          tk_nxt    = tk_r + 2'd1;
          state_nxt = ST_DOT;
        end
      end
      // Drop out on a separating axis, else advance the axis walk
      ST_CMP: begin
        if (sep) begin
          res_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (cross_r && (fi_r == 2'd2) && (fj_r == 2'd2)) begin
          res_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_AXIS;
          if (cross_r) begin
            if (fj_r == 2'd2) begin
              fj_nxt = '0;
              fi_nxt = fi_r + 2'd1;
            end else begin
              fj_nxt = fj_r + 2'd1;
            end
          end else if (fi_r != 2'd2) begin
            fi_nxt = fi_r + 2'd1;
          end else if (fb_r == BOX_A) begin
            fb_nxt = BOX_B;
            fi_nxt = '0;
          end else begin
            cross_nxt = 1'b1;
            fi_nxt    = '0;
            fj_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    cross_r <= cross_nxt;
    fb_r    <= fb_nxt;
    fi_r    <= fi_nxt;
    fj_r    <= fj_nxt;
    tb_r    <= tb_nxt;
    tk_r    <= tk_nxt;
    c_r     <= c_nxt;
    cnt_r   <= cnt_nxt;
    s_r     <= s_nxt;
    a_r     <= a_nxt;
    dist_r  <= dist_nxt;
    l_r     <= l_nxt;
    mag_r   <= mag_nxt;
    r_r     <= r_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_collides = res_r;

endmodule

// ===== sv/obb_chk.sv =====
// ----------------------------------------------------------------------------
// obb_chk
// Port-level checks of the overlap test unit, bound to the top level.
// ----------------------------------------------------------------------------
module obb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_mode,
  input logic [1:0] in_axis_index,
  input logic       out_valid
);
  import obb_pkg::*;

  // Reset clears the sequencer and the strobe
  a_reset: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or result after reset");

  // A trigger beat starts the test
  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == BOX_B) && (in_axis_index == AXIS_LAST) |=> busy)
    else $error("trigger beat did not start the test");

  // A load beat only stores
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !((in_mode == BOX_B) && (in_axis_index == AXIS_LAST))
    |=> !busy && !out_valid)
    else $error("load beat started work");

  // A result ends a test run and is a single strobe
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result outside a test run");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result repeated");

endmodule

bind obb_overlap_test_unit obb_chk u_obb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .in_axis_index (in_axis_index),
  .out_valid     (out_valid)
);

// ===== tb/obb_overlap_test_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_overlap_test_unit_tb
// Self-checking bench for the oriented box overlap unit. Box axes are loaded
// beat by beat. A bit-exact 128-bit predictor of the fifteen-axis test holds
// its own copy of both boxes and queues the expected collide flag for every
// box B axis 2 beat. Directed cases cover field extremes, ignored axis
// index 3, exact touching and degenerate cross axes. Random box pairs and
// noise beats follow, with random sender gaps and a full drain midway and at the end.
// ----------------------------------------------------------------------------
module obb_overlap_test_unit_tb;
  import obb_pkg::*;

  localparam int DW = DIR_WIDTH_DEF;
  localparam int PW = POS_WIDTH_DEF;
  localparam int FRAC_BITS = DW - 1;
  localparam int STALL_LIMIT = 20000;
  localparam int TEST_LATENCY = 600;
  localparam logic [1:0] AXIS_IGNORED = 2'd3;
  localparam logic signed [DW-1:0] DIR_NEG_ONE = {1'b1, {(DW - 1){1'b0}}};
  localparam logic signed [DW-1:0] DIR_POS_MAX = {1'b0, {(DW - 1){1'b1}}};

  typedef logic signed [127:0] acc_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_mode;
  logic [1:0]           in_axis_index;
  logic signed [DW-1:0] in_dir_x, in_dir_y, in_dir_z;
  logic [PW-2:0]        in_half_len;
  logic signed [PW-1:0] in_center_x, in_center_y, in_center_z;
  logic                 out_valid;
  logic                 out_collides;

  // Shadow copy of the stored boxes
  logic signed [DW-1:0] dir_store [18];
  logic [PW-2:0]        len_store [6];
  logic signed [PW-1:0] ctr_store [6];

  logic collide_q[$];
  logic exp_flag;
  int   mismatches;
  int   beats_taken;
  int   flags_seen;
  bit   gaps_on;

  obb_overlap_test_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_axis_index(in_axis_index),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_half_len(in_half_len),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_center_z(in_center_z),
    .out_valid(out_valid), .out_collides(out_collides)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic acc_t mag(acc_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic acc_t axis_dot(acc_t s [3], int row);
    acc_t acc = 0;
    for (int c = 0; c < 3; c++) acc += s[c] * acc_t'(dir_store[row * 3 + c]);
    return acc;
  endfunction

  // Sum of |s . axis_k| * len_k over the axes of one box, skipping one
  function automatic acc_t box_radius(acc_t s [3], int box, int skip);
    acc_t acc = 0;
    for (int k = 0; k < 3; k++)
      if (k != skip)
        acc += mag(axis_dot(s, box * 3 + k)) * acc_t'(len_store[box * 3 + k]);
    return acc;
  endfunction

  function automatic bit axis_separates(acc_t s [3], acc_t dvec [3], acc_t ra, acc_t rb);
    acc_t l = 0;
    for (int c = 0; c < 3; c++) l += s[c] * dvec[c];
    l = mag(l) <<< FRAC_BITS;
    return l > (ra + rb);
  endfunction

  function automatic bit boxes_overlap();
    acc_t dvec [3];
    acc_t s [3];
    acc_t a [3];
    acc_t q [3];
    acc_t own;
    for (int c = 0; c < 3; c++) dvec[c] = acc_t'(ctr_store[c]) - acc_t'(ctr_store[3 + c]);
    // face axes of both boxes
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) s[c] = acc_t'(dir_store[(b * 3 + i) * 3 + c]);
        own = acc_t'(len_store[b * 3 + i]) <<< (2 * FRAC_BITS);
        if (axis_separates(s, dvec, own, box_radius(s, 1 - b, 3))) return 1'b0;
      end
    // edge cross axes
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          a[c] = acc_t'(dir_store[i * 3 + c]);
          q[c] = acc_t'(dir_store[(3 + j) * 3 + c]);
        end
        s[0] = a[1] * q[2] - a[2] * q[1];
        s[1] = a[2] * q[0] - a[0] * q[2];
        s[2] = a[0] * q[1] - a[1] * q[0];
        if (axis_separates(s, dvec, box_radius(s, 0, i), box_radius(s, 1, j))) return 1'b0;
      end
    return 1'b1;
  endfunction

  // Update the shadow boxes with one accepted beat, queue the flag on a trigger
  function automatic void absorb_beat(logic mode, logic [1:0] ax, logic signed [DW-1:0] dx,
                                      logic signed [DW-1:0] dy, logic signed [DW-1:0] dz,
                                      logic [PW-2:0] len, logic signed [PW-1:0] cx,
                                      logic signed [PW-1:0] cy, logic signed [PW-1:0] cz);
    int row;
    if (ax == AXIS_IGNORED) return;
    row = int'(mode) * 3 + int'(ax);
    dir_store[row * 3] = dx;
    dir_store[row * 3 + 1] = dy;
    dir_store[row * 3 + 2] = dz;
    len_store[row] = len;
    ctr_store[int'(mode) * 3] = cx;
    ctr_store[int'(mode) * 3 + 1] = cy;
    ctr_store[int'(mode) * 3 + 2] = cz;
    if (mode == BOX_B && ax == AXIS_LAST) collide_q.push_back(boxes_overlap());
  endfunction

  // ---------------------------------------------------------------- driving
  // Present one beat and hold it until taken
  task automatic send_beat(logic mode, logic [1:0] ax, logic signed [DW-1:0] dx,
                           logic signed [DW-1:0] dy, logic signed [DW-1:0] dz,
                           logic [PW-2:0] len, logic signed [PW-1:0] cx,
                           logic signed [PW-1:0] cy, logic signed [PW-1:0] cz);
    start <= 1'b1;
    in_mode <= mode;
    in_axis_index <= ax;
    in_dir_x <= dx;
    in_dir_y <= dy;
    in_dir_z <= dz;
    in_half_len <= len;
    in_center_x <= cx;
    in_center_y <= cy;
    in_center_z <= cz;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    beats_taken++;
    absorb_beat(mode, ax, dx, dy, dz, len, cx, cy, cz);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic signed [DW-1:0] rand_dir();
    case ($urandom_range(0, 4))
      0: return DIR_NEG_ONE;
      1: return DIR_POS_MAX;
      2: return '0;
      default: return DW'($urandom);
    endcase
  endfunction

  // Random box pair; B axis 2 goes last so the test sees a full new pair
  task automatic send_box_pair(bit aligned);
    logic signed [PW-1:0] ca [3];
    logic signed [PW-1:0] cb [3];
    logic signed [DW-1:0] d [3];
    int order [5];
    int t;
    int k;
    for (int c = 0; c < 3; c++) begin
      ca[c] = $signed($urandom_range(0, 2 ** 24)) - (2 ** 23);
      cb[c] = ca[c] + $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
    end
    for (int i = 0; i < 5; i++) order[i] = i;
    for (int i = 4; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = order[i]; order[i] = order[k]; order[k] = t;
    end
    for (int n = 0; n < 6; n++) begin
      k = (n < 5) ? order[n] : 5;
      for (int c = 0; c < 3; c++)
        if (aligned) d[c] = (c == k % 3) ? (($urandom_range(0, 1) != 0) ?
                                            DIR_NEG_ONE : DIR_POS_MAX) : '0;
        else d[c] = rand_dir();
      if (k < 3)
        send_beat(BOX_A, 2'(k), d[0], d[1], d[2], (PW - 1)'($urandom_range(0, 2 ** 20)),
                  ca[0], ca[1], ca[2]);
      else
        send_beat(BOX_B, 2'(k - 3), d[0], d[1], d[2], (PW - 1)'($urandom_range(0, 2 ** 20)),
                  cb[0], cb[1], cb[2]);
    end
  endtask

  task automatic send_noise_beat();
    send_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), DW'($urandom),
              DW'($urandom), DW'($urandom), (PW - 1)'($urandom), PW'($urandom),
              PW'($urandom), PW'($urandom));
  endtask

  // Hold the sender until every queued flag has come back
  task automatic drain_flags();
    start <= 1'b0;
    while (collide_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests
  // Axis-aligned boxes offset on the x axis: face x touches when dx = la + lb
  task automatic test_touching();
    for (int gap = -1; gap <= 1; gap++) begin
      send_beat(BOX_A, 2'd0, DIR_NEG_ONE, '0, '0, 31'd65536, 32'sd0, 32'sd0, 32'sd0);
      send_beat(BOX_A, 2'd1, '0, DIR_NEG_ONE, '0, 31'd65536, 32'sd0, 32'sd0, 32'sd0);
      send_beat(BOX_A, 2'd2, '0, '0, DIR_NEG_ONE, 31'd65536, 32'sd0, 32'sd0, 32'sd0);
      send_beat(BOX_B, 2'd0, DIR_NEG_ONE, '0, '0, 31'd32768, 32'sd0, 32'sd0, 32'sd0);
      send_beat(BOX_B, 2'd1, '0, DIR_NEG_ONE, '0, 31'd32768, 32'sd0, 32'sd0, 32'sd0);
      send_beat(BOX_B, 2'd2, '0, '0, DIR_NEG_ONE, 31'd32768,
                32'sd98304 + gap, 32'sd0, 32'sd0);
    end
  endtask

  // Field extremes and ignored axis index 3 beats
  task automatic test_extremes();
    send_beat(BOX_A, AXIS_IGNORED, DIR_POS_MAX, DIR_NEG_ONE, '0, '1, '1, '0, '1);
    send_beat(BOX_B, AXIS_IGNORED, DIR_NEG_ONE, DIR_POS_MAX, DIR_POS_MAX, '0, '0, '1, '0);
    send_beat(BOX_A, 2'd1, DIR_POS_MAX, DIR_POS_MAX, DIR_NEG_ONE, '1,
              {1'b1, {(PW - 1){1'b0}}}, {1'b1, {(PW - 1){1'b0}}}, {1'b0, {(PW - 1){1'b1}}});
    send_beat(BOX_B, 2'd2, DIR_NEG_ONE, DIR_POS_MAX, '0, '1,
              {1'b0, {(PW - 1){1'b1}}}, {1'b0, {(PW - 1){1'b1}}}, {1'b1, {(PW - 1){1'b0}}});
    send_beat(BOX_B, 2'd2, DIR_POS_MAX, '0, DIR_NEG_ONE, '0, '0, '0, '0);
    send_beat(BOX_B, AXIS_IGNORED, '0, '0, '0, '0, '0, '0, '0);
    send_beat(BOX_B, 2'd2, '0, DIR_NEG_ONE, DIR_NEG_ONE, '1, '1, '1, '1);
  endtask

  task automatic test_random_pairs(int pairs);
    for (int n = 0; n < pairs; n++) send_box_pair($urandom_range(0, 2) == 0);
  endtask

  // Mostly single-axis updates on a full pair, with full-range noise
  task automatic test_mixed(int beats);
    for (int n = 0; n < beats; n++)
      if ($urandom_range(0, 2) == 0) send_noise_beat();
      else send_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)), rand_dir(),
                     rand_dir(), rand_dir(), (PW - 1)'($urandom_range(0, 2 ** 20)),
                     $signed($urandom_range(0, 2 ** 22)) - (2 ** 21),
                     $signed($urandom_range(0, 2 ** 22)) - (2 ** 21),
                     $signed($urandom_range(0, 2 ** 22)) - (2 ** 21));
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      flags_seen++;
      if (collide_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: collides=%0b", out_collides);
      end else begin
        exp_flag = collide_q.pop_front();
        if (exp_flag !== out_collides) begin
          mismatches++;
          if (mismatches <= 10)
            $display("collides mismatch: expected %0b, got %0b", exp_flag, out_collides);
        end
      end
    end
  end

  // Watchdog: stop when no beat moves for too long
  int stall_cnt;
  int last_beats;
  int last_flags;
  always @(posedge clk) begin
    if (beats_taken != last_beats || flags_seen != last_flags) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    last_beats <= beats_taken;
    last_flags <= flags_seen;
    if (stall_cnt == STALL_LIMIT) begin
      $display("obb_overlap_test_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = BOX_A;
    in_axis_index = '0;
    in_dir_x = '0;
    in_dir_y = '0;
    in_dir_z = '0;
    in_half_len = '0;
    in_center_x = '0;
    in_center_y = '0;
    in_center_z = '0;
    mismatches = 0;
    beats_taken = 0;
    flags_seen = 0;
    gaps_on = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_touching();
    test_extremes();
    gaps_on = 1'b1;
    test_random_pairs(20);
    test_mixed(70);
    drain_flags();
    test_random_pairs(15);
    test_mixed(40);
    gaps_on = 1'b0;
    test_random_pairs(10);
    test_mixed(20);

    drain_flags();
    repeat (TEST_LATENCY) @(posedge clk);
    if (mismatches == 0 && collide_q.size() == 0)
      $display("obb_overlap_test_unit regression: pass");
    else
      $display("obb_overlap_test_unit regression: fail");
    $finish;
  end

endmodule
